>>> rtl/core/awrd_pkg.sv
package awrd_pkg;

    // Fixed field widths
    localparam int CFG_W             = 13;
    localparam int CFG_IDX_W         = 2;
    localparam int COLOR_W           = 8;
    localparam int POS_OUT_W         = 12;
    localparam int MAX_DIMENSION_DEF = 4096;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SOURCE_WIDTH  = 2'd0,
        CFG_SOURCE_HEIGHT = 2'd1,
        CFG_TARGET_WIDTH  = 2'd2,
        CFG_TARGET_HEIGHT = 2'd3
    } cfg_idx_t;

    // Source pixel
    typedef struct packed {
        logic [COLOR_W-1:0] in_red;
        logic [COLOR_W-1:0] in_green;
        logic [COLOR_W-1:0] in_blue;
    } in_t;

    // Finished target pixel
    typedef struct packed {
        logic [COLOR_W-1:0]   out_red;
        logic [COLOR_W-1:0]   out_green;
        logic [COLOR_W-1:0]   out_blue;
        logic [POS_OUT_W-1:0] out_column;
        logic [POS_OUT_W-1:0] out_row;
        logic                 frame_done;
    } out_t;

    // Controller to datapath
    typedef struct packed {
        logic clr_step;
        logic take;
        logic split;
        logic ent_rd;
        logic ent_next;
        logic mac;
        logic rs_mul;
        logic rs_start;
        logic rs_set;
        logic avg_start;
        logic out_load;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic clr_last;
        logic rs_pending;
        logic ent_live;
        logic ent_last;
        logic emit;
        logic rs_done;
        logic avg_done;
        logic out_free;
    } sts_t;

endpackage

>>> rtl/core/awrd_div.sv
module awrd_div #(
    parameter int NW = 36,
    parameter int DW = 27,
    parameter int QW = 9
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic [QW-1:0] quot,
    output logic          over,
    output logic          done
);

    localparam int XW   = (NW > DW + QW) ? NW : DW + QW;
    localparam int CNTW = (QW > 1) ? $clog2(QW) : 1;

    logic [XW-1:0]   rem_reg, rem_next;
    logic [XW-1:0]   dsh_reg, dsh_next;
    logic [QW-1:0]   q_reg, q_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic            over_reg, over_next;
    logic            ge;

    // One quotient bit per cycle, restoring
    assign ge = rem_reg >= dsh_reg;

    always_comb
    begin
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        over_next = over_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = XW'(num);
            dsh_next  = XW'(den) << (QW - 1);
            over_next = XW'(num) >= (XW'(den) << QW);
            q_next    = '0;
            cnt_next  = CNTW'(QW - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (ge)
            begin
                rem_next = rem_reg - dsh_reg;
            end
            q_next   = {q_reg[QW-2:0], ge};
            dsh_next = dsh_reg >> 1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - CNTW'(1);
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Working values
    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        dsh_reg  <= dsh_next;
        q_reg    <= q_next;
        over_reg <= over_next;
    end

    assign quot = q_reg;
    assign over = over_reg;
    assign done = done_reg;

endmodule

>>> rtl/core/awrd_ctrl.sv
module awrd_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          src_valid,
    output logic          src_stall,
    input  awrd_pkg::sts_t sts,
    output awrd_pkg::cmd_t cmd
);

    import awrd_pkg::*;

    typedef enum logic [10:0] {
        S_CLEAR  = 11'b00000000001,
        S_IDLE   = 11'b00000000010,
        S_RS_MUL = 11'b00000000100,
        S_RS_GO  = 11'b00000001000,
        S_RS_DIV = 11'b00000010000,
        S_SPLIT  = 11'b00000100000,
        S_ENT    = 11'b00001000000,
        S_MAC    = 11'b00010000000,
        S_FIN    = 11'b00100000000,
        S_DIV    = 11'b01000000000,
        S_OUT    = 11'b10000000000
    } state_t;

    state_t state_reg, state_next;

    // Input is open only when idle and the position trackers are in step
    assign src_stall = !((state_reg == S_IDLE) && !sts.rs_pending);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (sts.rs_pending)
                begin
                    state_next = S_RS_MUL;
                end
                else if (src_valid)
                begin
                    cmd.take   = 1'b1;
                    state_next = S_SPLIT;
                end
            end
            S_RS_MUL:
            begin
                cmd.rs_mul = 1'b1;
                state_next = S_RS_GO;
            end
            S_RS_GO:
            begin
                cmd.rs_start = 1'b1;
                state_next   = S_RS_DIV;
            end
            S_RS_DIV:
            begin
                if (sts.rs_done)
                begin
                    cmd.rs_set = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_SPLIT:
            begin
                cmd.split  = 1'b1;
                state_next = S_ENT;
            end
            // Walk the four overlap entries, skipping empty ones
            S_ENT:
            begin
                if (sts.ent_live)
                begin
                    cmd.ent_rd = 1'b1;
                    state_next = S_MAC;
                end
                else if (sts.ent_last)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    cmd.ent_next = 1'b1;
                end
            end
            S_MAC:
            begin
                cmd.mac = 1'b1;
                if (sts.ent_last)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    cmd.ent_next = 1'b1;
                    state_next   = S_ENT;
                end
            end
            S_FIN:
            begin
                if (sts.emit)
                begin
                    cmd.avg_start = 1'b1;
                    state_next    = S_DIV;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_DIV:
            begin
                if (sts.avg_done)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

>>> rtl/core/awrd_datapath.sv
module awrd_datapath #(
    parameter int MAX_DIM = awrd_pkg::MAX_DIMENSION_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [awrd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [awrd_pkg::CFG_W-1:0]     cfg_data,
    input  awrd_pkg::in_t                  src_data,
    input  logic                           dst_stall,
    output logic                           dst_valid,
    output awrd_pkg::out_t                 dst_data,
    input  awrd_pkg::cmd_t                 cmd,
    output awrd_pkg::sts_t                 sts
);

    import awrd_pkg::*;

    localparam int CW     = $clog2(MAX_DIM + 1);
    localparam int PW     = $clog2(MAX_DIM);
    localparam int AW     = 2 * CW;
    localparam int SUM_W  = COLOR_W + 2 * CW;
    localparam int MW     = $clog2(2 * MAX_DIM);
    localparam int IW     = MW + 1;
    localparam int EW     = (CFG_W > CW) ? CFG_W : CW;
    localparam int AVG_QW = COLOR_W + 1;
    localparam int NUM_W  = SUM_W + 2;
    localparam int DEPTH  = 2 * MAX_DIM;

    // Size clamping: zero reads as one, then limited by the maximum and the bound
    function automatic logic [CW-1:0] eff(input logic [CFG_W-1:0] v,
                                          input logic [CW-1:0] lim);
        logic [EW-1:0] x;
        x = EW'(v);
        if (x == '0)
        begin
            x = EW'(1);
        end
        if (x > EW'(MAX_DIM))
        begin
            x = EW'(MAX_DIM);
        end
        if (x > EW'(lim))
        begin
            x = EW'(lim);
        end
        return CW'(x);
    endfunction

    // Registers
    logic [CFG_W-1:0]   src_w_reg, src_h_reg, tgt_w_reg, tgt_h_reg;
    logic [PW-1:0]      pos_c_reg, pos_r_reg;
    logic [AW-1:0]      ca_reg, ce_reg, ra_reg, re_reg;
    logic [CW-1:0]      cf_reg, rf_reg;
    logic               pend_reg;
    logic [1:0]         ent_reg;
    logic [MW-1:0]      clr_reg;
    logic               emit_reg;
    logic               out_valid_reg;
    logic [CW-1:0]      wx0_reg, wx1_reg, wy0_reg, wy1_reg;
    logic [CW-1:0]      cx_reg, cy_reg;
    in_t                pix_reg;
    logic [AW-1:0]      w_reg;
    logic [MW-1:0]      addr_reg;
    logic [3*SUM_W-1:0] rd_reg;
    logic [SUM_W-1:0]   acc_r_reg, acc_g_reg, acc_b_reg;
    logic [AW-1:0]      d_reg;
    out_t               out_reg;

    logic [3*SUM_W-1:0] mem [DEPTH];

    logic [CW-1:0]      sw, sh, tw, th;
    logic               restart;
    logic [AW-1:0]      cb, rb;
    logic               cge, rge, cfin, rfin, cadv, radv;
    logic [CW-1:0]      cw0, cw1, rw0, rw1;
    logic               col_wrap, row_wrap;
    logic               ent_i, ent_j, bank;
    logic [CW-1:0]      wxj, wyi;
    logic [CW:0]        cxj;
    logic [IW-1:0]      idx;
    logic               live, emit_here;
    logic [SUM_W-1:0]   new_r, new_g, new_b;
    logic [3*SUM_W-1:0] wdata;
    logic [CW-1:0]      col_q, row_q;
    logic               col_over, row_over, col_done, row_done;
    logic [AVG_QW-1:0]  q_r, q_g, q_b;
    logic               ov_r, ov_g, ov_b, dn_r, dn_g, dn_b;
    logic [NUM_W-1:0]   num_r, num_g, num_b;
    logic [AW:0]        den2;
    logic [COLOR_W-1:0] avg_r, avg_g, avg_b;

    // Effective sizes
    assign sw = eff(src_w_reg, CW'(MAX_DIM));
    assign sh = eff(src_h_reg, CW'(MAX_DIM));
    assign tw = eff(tgt_w_reg, sw);
    assign th = eff(tgt_h_reg, sh);

    assign restart = (CW'(pos_c_reg) >= sw) || (CW'(pos_r_reg) >= sh);

    // Column split of span [a, a+t) against target edge
    assign cb   = ca_reg + AW'(tw);
    assign cge  = ce_reg >= cb;
    assign cw0  = cge ? tw : CW'(ce_reg - ca_reg);
    assign cw1  = cge ? '0 : CW'(cb - ce_reg);
    assign cfin = cge ? (ce_reg == cb) : 1'b1;
    assign cadv = ce_reg <= cb;

    // Row split
    assign rb   = ra_reg + AW'(th);
    assign rge  = re_reg >= rb;
    assign rw0  = rge ? th : CW'(re_reg - ra_reg);
    assign rw1  = rge ? '0 : CW'(rb - re_reg);
    assign rfin = rge ? (re_reg == rb) : 1'b1;
    assign radv = re_reg <= rb;

    assign col_wrap = (CW'(pos_c_reg) + CW'(1)) >= sw;
    assign row_wrap = (CW'(pos_r_reg) + CW'(1)) >= sh;

    // Current overlap entry: bit 1 picks the row, bit 0 the column
    assign ent_i = ent_reg[1];
    assign ent_j = ent_reg[0];
    assign wyi   = ent_i ? wy1_reg : wy0_reg;
    assign wxj   = ent_j ? wx1_reg : wx0_reg;
    assign bank  = cy_reg[0] ^ ent_i;
    assign cxj   = (CW + 1)'(cx_reg) + (CW + 1)'(ent_j);
    assign idx   = bank ? (IW'(MAX_DIM) + IW'(cxj)) : IW'(cxj);
    assign live  = (wyi != '0) && (wxj != '0) && (idx < IW'(DEPTH));
    assign emit_here = emit_reg && (ent_reg == 2'd0);

    // Weighted accumulate
    assign new_r = rd_reg[3*SUM_W-1:2*SUM_W]
                 + SUM_W'(SUM_W'(pix_reg.in_red) * SUM_W'(w_reg));
    assign new_g = rd_reg[2*SUM_W-1:SUM_W]
                 + SUM_W'(SUM_W'(pix_reg.in_green) * SUM_W'(w_reg));
    assign new_b = rd_reg[SUM_W-1:0]
                 + SUM_W'(SUM_W'(pix_reg.in_blue) * SUM_W'(w_reg));
    assign wdata = emit_here ? '0 : {new_r, new_g, new_b};

    // Tracker resync dividers: f = a / s
    awrd_div #(.NW(AW), .DW(CW), .QW(CW)) u_div_col (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.rs_start),
        .num   (ca_reg),
        .den   (sw),
        .quot  (col_q),
        .over  (col_over),
        .done  (col_done)
    );

    awrd_div #(.NW(AW), .DW(CW), .QW(CW)) u_div_row (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.rs_start),
        .num   (ra_reg),
        .den   (sh),
        .quot  (row_q),
        .over  (row_over),
        .done  (row_done)
    );

    // Averages: (2*sum + D) / (2*D)
    assign den2  = {d_reg, 1'b0};
    assign num_r = NUM_W'({acc_r_reg, 1'b0}) + NUM_W'(d_reg);
    assign num_g = NUM_W'({acc_g_reg, 1'b0}) + NUM_W'(d_reg);
    assign num_b = NUM_W'({acc_b_reg, 1'b0}) + NUM_W'(d_reg);

    awrd_div #(.NW(NUM_W), .DW(AW + 1), .QW(AVG_QW)) u_div_r (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.avg_start),
        .num   (num_r),
        .den   (den2),
        .quot  (q_r),
        .over  (ov_r),
        .done  (dn_r)
    );

    awrd_div #(.NW(NUM_W), .DW(AW + 1), .QW(AVG_QW)) u_div_g (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.avg_start),
        .num   (num_g),
        .den   (den2),
        .quot  (q_g),
        .over  (ov_g),
        .done  (dn_g)
    );

    awrd_div #(.NW(NUM_W), .DW(AW + 1), .QW(AVG_QW)) u_div_b (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.avg_start),
        .num   (num_b),
        .den   (den2),
        .quot  (q_b),
        .over  (ov_b),
        .done  (dn_b)
    );

    // Clamp to full scale
    assign avg_r = (ov_r || q_r[COLOR_W]) ? '1 : q_r[COLOR_W-1:0];
    assign avg_g = (ov_g || q_g[COLOR_W]) ? '1 : q_g[COLOR_W-1:0];
    assign avg_b = (ov_b || q_b[COLOR_W]) ? '1 : q_b[COLOR_W-1:0];

    // Control state: configuration, positions, trackers, sequencing
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_w_reg     <= CFG_W'(1);
            src_h_reg     <= CFG_W'(1);
            tgt_w_reg     <= CFG_W'(1);
            tgt_h_reg     <= CFG_W'(1);
            pos_c_reg     <= '0;
            pos_r_reg     <= '0;
            ca_reg        <= '0;
            cf_reg        <= '0;
            ce_reg        <= AW'(1);
            ra_reg        <= '0;
            rf_reg        <= '0;
            re_reg        <= AW'(1);
            pend_reg      <= 1'b1;
            ent_reg       <= '0;
            clr_reg       <= '0;
            emit_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // A rebuild takes the request; a write landing during it asks again
            if (cmd.rs_mul)
            begin
                pend_reg <= 1'b0;
            end

            if (cfg_we)
            begin
                pend_reg <= 1'b1;
                case (cfg_idx_t'(cfg_index))
                    CFG_SOURCE_WIDTH:  src_w_reg <= cfg_data;
                    CFG_SOURCE_HEIGHT: src_h_reg <= cfg_data;
                    CFG_TARGET_WIDTH:  tgt_w_reg <= cfg_data;
                    CFG_TARGET_HEIGHT: tgt_h_reg <= cfg_data;
                    default:           pend_reg  <= 1'b1;
                endcase
            end

            if (cmd.clr_step)
            begin
                clr_reg <= clr_reg + MW'(1);
            end

            // Recompute trackers from the position after a size change
            if (cmd.rs_mul)
            begin
                ca_reg <= AW'(AW'(pos_c_reg) * AW'(tw));
                ra_reg <= AW'(AW'(pos_r_reg) * AW'(th));
            end
            if (cmd.rs_set)
            begin
                cf_reg   <= col_q;
                ce_reg   <= AW'((AW'(col_q) + AW'(1)) * AW'(sw));
                rf_reg   <= row_q;
                re_reg   <= AW'((AW'(row_q) + AW'(1)) * AW'(sh));
            end

            // Position off the image restarts the frame
            if (cmd.take && restart)
            begin
                pos_c_reg <= '0;
                pos_r_reg <= '0;
                ca_reg    <= '0;
                cf_reg    <= '0;
                ce_reg    <= AW'(sw);
                ra_reg    <= '0;
                rf_reg    <= '0;
                re_reg    <= AW'(sh);
            end

            // Latch weights, then step to the next source pixel
            if (cmd.split)
            begin
                emit_reg <= cfin && rfin;
                ent_reg  <= '0;
                if (col_wrap)
                begin
                    pos_c_reg <= '0;
                    ca_reg    <= '0;
                    cf_reg    <= '0;
                    ce_reg    <= AW'(sw);
                    if (row_wrap)
                    begin
                        pos_r_reg <= '0;
                        ra_reg    <= '0;
                        rf_reg    <= '0;
                        re_reg    <= AW'(sh);
                    end
                    else
                    begin
                        pos_r_reg <= pos_r_reg + PW'(1);
                        ra_reg    <= rb;
                        if (radv)
                        begin
                            rf_reg <= rf_reg + CW'(1);
                            re_reg <= re_reg + AW'(sh);
                        end
                    end
                end
                else
                begin
                    pos_c_reg <= pos_c_reg + PW'(1);
                    ca_reg    <= cb;
                    if (cadv)
                    begin
                        cf_reg <= cf_reg + CW'(1);
                        ce_reg <= ce_reg + AW'(sw);
                    end
                end
            end

            if (cmd.ent_next)
            begin
                ent_reg <= ent_reg + 2'd1;
            end

            // Output register: free once its transfer completes
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !dst_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        d_reg <= AW'(AW'(sw) * AW'(sh));
        if (cmd.take)
        begin
            pix_reg <= src_data;
        end
        if (cmd.split)
        begin
            cx_reg    <= cf_reg;
            cy_reg    <= rf_reg;
            wx0_reg   <= cw0;
            wx1_reg   <= cw1;
            wy0_reg   <= rw0;
            wy1_reg   <= rw1;
            acc_r_reg <= '0;
            acc_g_reg <= '0;
            acc_b_reg <= '0;
        end
        if (cmd.ent_rd)
        begin
            addr_reg <= idx[MW-1:0];
            w_reg    <= AW'(AW'(wxj) * AW'(wyi));
        end
        if (cmd.mac && emit_here)
        begin
            acc_r_reg <= new_r;
            acc_g_reg <= new_g;
            acc_b_reg <= new_b;
        end
        if (cmd.out_load)
        begin
            out_reg.out_red    <= avg_r;
            out_reg.out_green  <= avg_g;
            out_reg.out_blue   <= avg_b;
            out_reg.out_column <= POS_OUT_W'(cx_reg);
            out_reg.out_row    <= POS_OUT_W'(cy_reg);
            out_reg.frame_done <= (cx_reg == CW'(tw - CW'(1)))
                               && (cy_reg == CW'(th - CW'(1)));
        end
    end

    // Accumulator memory: two target rows, three channels per word
    always_ff @(posedge clk)
    begin
        if (cmd.clr_step)
        begin
            mem[clr_reg] <= '0;
        end
        else if (cmd.mac)
        begin
            mem[addr_reg] <= wdata;
        end
        if (cmd.ent_rd)
        begin
            rd_reg <= mem[idx[MW-1:0]];
        end
    end

    // Status
    assign sts.clr_last   = clr_reg == MW'(DEPTH - 1);
    assign sts.rs_pending = pend_reg;
    assign sts.ent_live   = live;
    assign sts.ent_last   = ent_reg == 2'd3;
    assign sts.emit       = emit_reg;
    assign sts.rs_done    = col_done && row_done && !col_over && !row_over
                          || col_done && row_done;
    assign sts.avg_done   = dn_r && dn_g && dn_b;
    assign sts.out_free   = !out_valid_reg || !dst_stall;

    assign dst_valid = out_valid_reg;
    assign dst_data  = out_reg;

endmodule

>>> rtl/core/area_weighted_rgb_downscaler_core.sv
// Channel   Handshake              Payload            Notes
// source    src_valid / src_stall  src_data (in_t)    one RGB pixel, raster order
// result    dst_valid / dst_stall  dst_data (out_t)   one finished target pixel
// config    cfg_we                 cfg_index/cfg_data write only, when idle
//
// A source pixel skips each empty overlap entry; each filled one is read, then
// accumulated and written back through the single read-modify-write port of the
// accumulator memory. A pixel that finishes a target pixel also passes through
// the bit-serial divide (one quotient bit a cycle) and the load of the output
// register, and waits while a stalled result still holds that register.
// After reset the accumulator memory is cleared word by word;
// after reset and after each register write the position trackers are rebuilt
// by a multiply and a bit-serial divide, again if a write lands meanwhile.
// A stalled result holds its register while the next pixel is taken.
module area_weighted_rgb_downscaler_core #(
    parameter int MAX_DIMENSION = awrd_pkg::MAX_DIMENSION_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [awrd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [awrd_pkg::CFG_W-1:0]     cfg_data,
    input  logic                           src_valid,
    output logic                           src_stall,
    input  awrd_pkg::in_t                  src_data,
    output logic                           dst_valid,
    input  logic                           dst_stall,
    output awrd_pkg::out_t                 dst_data
);

    import awrd_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // Sequencer
    awrd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Accumulators, trackers, dividers and output register
    awrd_datapath #(.MAX_DIM(MAX_DIMENSION)) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .src_data  (src_data),
        .dst_stall (dst_stall),
        .dst_valid (dst_valid),
        .dst_data  (dst_data),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

>>> test/area_weighted_rgb_downscaler_core_test.sv
module area_weighted_rgb_downscaler_core_test;
    import awrd_pkg::*;

    localparam int MAX_DIM   = MAX_DIMENSION_DEF;
    localparam int BANK_SIZE = 2 * MAX_DIM;
    localparam int SETTLE    = 40;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data = '0;
    logic                 src_valid = 1'b0;
    logic                 src_stall;
    in_t                  src_data = '0;
    logic                 dst_valid;
    logic                 dst_stall = 1'b0;
    out_t                 dst_data;

    area_weighted_rgb_downscaler_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .src_data  (src_data),
        .dst_valid (dst_valid),
        .dst_stall (dst_stall),
        .dst_data  (dst_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Register shadow and accumulator copy used for prediction
    logic [CFG_W-1:0]  size_reg [4] = '{default: 1};
    longint unsigned   area_sum [3][BANK_SIZE];
    longint unsigned   pos_col = 0;
    longint unsigned   pos_row = 0;

    in_t  pixel_q [$];
    out_t expected_pixels [$];

    int   errors = 0;
    int   pixels_taken = 0;
    int   pixels_out = 0;
    int   frames_done = 0;
    int   size_sets = 0;
    bit   burst = 0;
    int   src_gap = 0;
    int   stall_left = 0;

    function automatic longint unsigned clamp_size(longint unsigned v, longint unsigned lim);
        if (v == 0)
            v = 1;
        if (v > MAX_DIM)
            v = MAX_DIM;
        if (v > lim)
            v = lim;
        return v;
    endfunction

    // Split the span [pos*t, pos*t+t) over target pixels of length s
    function automatic void span_split(input longint unsigned pos, s, t,
                                       output longint unsigned first, w0, w1,
                                       output bit finishes);
        longint unsigned a, b, edge_pos;
        a = pos * t;
        b = a + t;
        first = a / s;
        edge_pos = (first + 1) * s;
        if (edge_pos >= b)
        begin
            w0 = t;
            w1 = 0;
            finishes = (edge_pos == b);
        end
        else
        begin
            w0 = edge_pos - a;
            w1 = b - edge_pos;
            finishes = 1;
        end
    endfunction

    function automatic logic [COLOR_W-1:0] rounded_mean(longint unsigned sum, longint unsigned d);
        longint unsigned v;
        v = (2 * sum + d) / (2 * d);
        return (v > 255) ? 8'd255 : v[COLOR_W-1:0];
    endfunction

    // Accumulate one source pixel and queue the target pixel it finishes, if any
    function automatic void accumulate_pixel(in_t px);
        longint unsigned sw, sh, tw, th, cx, cy, d, idx, w;
        longint unsigned wx [2];
        longint unsigned wy [2];
        longint unsigned chan [3];
        bit col_done, row_done;
        int bank;
        out_t res;
        sw = clamp_size(size_reg[CFG_SOURCE_WIDTH], MAX_DIM);
        sh = clamp_size(size_reg[CFG_SOURCE_HEIGHT], MAX_DIM);
        tw = clamp_size(size_reg[CFG_TARGET_WIDTH], sw);
        th = clamp_size(size_reg[CFG_TARGET_HEIGHT], sh);
        chan[0] = px.in_red;
        chan[1] = px.in_green;
        chan[2] = px.in_blue;
        // position left off the image after a size change
        if (pos_col >= sw || pos_row >= sh)
        begin
            pos_col = 0;
            pos_row = 0;
        end
        span_split(pos_col, sw, tw, cx, wx[0], wx[1], col_done);
        span_split(pos_row, sh, th, cy, wy[0], wy[1], row_done);
        bank = cy % 2;
        for (int i = 0; i < 2; i++)
        begin
            if (wy[i] == 0)
                continue;
            for (int j = 0; j < 2; j++)
            begin
                if (wx[j] == 0)
                    continue;
                w = wx[j] * wy[i];
                idx = longint'(bank ^ i) * MAX_DIM + cx + j;
                if (idx >= BANK_SIZE)
                    continue;
                for (int c = 0; c < 3; c++)
                    area_sum[c][idx] += chan[c] * w;
            end
        end
        if (col_done && row_done)
        begin
            d = sw * sh;
            idx = longint'(bank) * MAX_DIM + cx;
            res = '0;
            res.out_red = rounded_mean(area_sum[0][idx], d);
            res.out_green = rounded_mean(area_sum[1][idx], d);
            res.out_blue = rounded_mean(area_sum[2][idx], d);
            for (int c = 0; c < 3; c++)
                area_sum[c][idx] = 0;
            res.out_column = cx[POS_OUT_W-1:0];
            res.out_row = cy[POS_OUT_W-1:0];
            res.frame_done = (cx == tw - 1 && cy == th - 1);
            expected_pixels.push_back(res);
        end
        pos_col++;
        if (pos_col >= sw)
        begin
            pos_col = 0;
            pos_row++;
            if (pos_row >= sh)
                pos_row = 0;
        end
    endfunction

    // Mostly no gap, some short ones, a few long ones, none in burst stretches
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 19);
        if (burst || r < 11)
            return 0;
        if (r < 18)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Source driver: predicts on each accepted transfer
    always @(posedge clk)
    begin : src_drive
        logic nxt_valid;
        in_t  nxt_data;
        if (rst_n)
        begin
            nxt_valid = src_valid;
            nxt_data = src_data;
            if (src_valid && !src_stall)
            begin
                accumulate_pixel(src_data);
                pixels_taken++;
                nxt_valid = 1'b0;
            end
            if (!nxt_valid)
            begin
                if (src_gap > 0)
                    src_gap--;
                else if (pixel_q.size() > 0)
                begin
                    nxt_data = pixel_q.pop_front();
                    nxt_valid = 1'b1;
                    src_gap = idle_len();
                end
            end
            src_valid <= nxt_valid;
            src_data <= nxt_data;
        end
    end

    // Result monitor and random back-pressure
    always @(posedge clk)
    begin : dst_check
        out_t want;
        if (rst_n)
        begin
            if (dst_valid && !dst_stall)
            begin
                pixels_out++;
                if (expected_pixels.size() == 0)
                begin
                    $error("unexpected result transfer: %p", dst_data);
                    errors++;
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    if (dst_data.frame_done)
                        frames_done++;
                    if (dst_data.out_red !== want.out_red)
                    begin
                        $error("out_red expected %0d got %0d", want.out_red, dst_data.out_red);
                        errors++;
                    end
                    if (dst_data.out_green !== want.out_green)
                    begin
                        $error("out_green expected %0d got %0d", want.out_green,
                               dst_data.out_green);
                        errors++;
                    end
                    if (dst_data.out_blue !== want.out_blue)
                    begin
                        $error("out_blue expected %0d got %0d", want.out_blue, dst_data.out_blue);
                        errors++;
                    end
                    if (dst_data.out_column !== want.out_column)
                    begin
                        $error("out_column expected %0d got %0d", want.out_column,
                               dst_data.out_column);
                        errors++;
                    end
                    if (dst_data.out_row !== want.out_row)
                    begin
                        $error("out_row expected %0d got %0d", want.out_row, dst_data.out_row);
                        errors++;
                    end
                    if (dst_data.frame_done !== want.frame_done)
                    begin
                        $error("frame_done expected %0d got %0d", want.frame_done,
                               dst_data.frame_done);
                        errors++;
                    end
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                dst_stall <= 1'b1;
            end
            else
            begin
                stall_left = idle_len();
                dst_stall <= 1'b0;
            end
        end
    end

    function automatic in_t pick_pixel();
        in_t px;
        px = in_t'($urandom);
        case ($urandom_range(0, 9))
            0: px = '0;
            1: px = '1;
            default: ;
        endcase
        return px;
    endfunction

    task automatic queue_pixels(int n);
        for (int i = 0; i < n; i++)
            pixel_q.push_back(pick_pixel());
    endtask

    // Wait until every pixel is taken and every result has come back
    task automatic drain();
        while (pixel_q.size() > 0 || src_valid || expected_pixels.size() > 0)
            @(posedge clk);
    endtask

    task automatic set_sizes(logic [CFG_W-1:0] sw, sh, tw, th);
        cfg_idx_t order [4];
        logic [CFG_W-1:0] vals [4];
        order = '{CFG_SOURCE_WIDTH, CFG_SOURCE_HEIGHT, CFG_TARGET_WIDTH, CFG_TARGET_HEIGHT};
        vals = '{sw, sh, tw, th};
        drain();
        // a pixel that finished nothing may still be in the datapath
        repeat (SETTLE) @(posedge clk);
        for (int i = 0; i < 4; i++)
        begin
            @(posedge clk);
            cfg_we <= 1'b1;
            cfg_index <= order[i];
            cfg_data <= vals[i];
            size_reg[order[i]] = vals[i];
        end
        @(posedge clk);
        cfg_we <= 1'b0;
        size_sets++;
        burst = ($urandom_range(0, 3) == 0);
    endtask

    initial
    begin : stimulus
        int sw, sh, tw, th, n, kind;
        bit paused;
        for (int c = 0; c < 3; c++)
            for (int i = 0; i < BANK_SIZE; i++)
                area_sum[c][i] = 0;
        paused = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // directed: reset sizes, extremes of the colour fields
        pixel_q.push_back('0);
        pixel_q.push_back('1);
        pixel_q.push_back(in_t'(24'hA5_5A_C3));
        // zero sizes behave as one
        set_sizes(0, 0, 0, 0);
        pixel_q.push_back(in_t'(24'h3C_C3_69));
        pixel_q.push_back('1);
        // oversize width, upscale request on height
        set_sizes(13'h1FFF, 1, 13'h1FFF, 13'h1FFF);
        pixel_q.push_back('1);
        pixel_q.push_back('0);
        queue_pixels(2);
        // 3x3 to 2x2, full frame with straddling pixels
        set_sizes(3, 3, 2, 2);
        for (int i = 0; i < 9; i++)
            pixel_q.push_back((i % 2) ? in_t'('1) : in_t'(24'h01_80_FE));
        // narrow the image mid-frame so the position falls off it
        set_sizes(7, 2, 3, 1);
        queue_pixels(4);
        set_sizes(2, 2, 1, 1);
        queue_pixels(4);

        while (pixels_taken + pixel_q.size() < 430)
        begin
            kind = $urandom_range(0, 19);
            sw = $urandom_range(1, 12);
            sh = $urandom_range(1, 10);
            tw = $urandom_range(1, sw);
            th = $urandom_range(1, sh);
            n = sw * sh + (($urandom_range(0, 3) == 0) ? $urandom_range(0, sw) : 0);
            if (kind == 14)
            begin
                tw = sw + $urandom_range(1, 5);
                th = sh + $urandom_range(0, 3);
            end
            else if (kind == 15)
            begin
                sw = 0;
                tw = $urandom_range(0, 2);
                n = sh + 2;
            end
            else if (kind >= 16 && kind < 18)
            begin
                sw = $urandom_range(3000, 8191);
                sh = $urandom_range(1, 3);
                tw = ($urandom_range(0, 1)) ? sw - $urandom_range(0, 2) : $urandom_range(1, 8191);
                th = $urandom_range(1, sh);
                n = $urandom_range(20, 40);
            end
            else if (kind >= 18)
            begin
                sw = $urandom_range(1, 3);
                sh = $urandom_range(3000, 8191);
                tw = $urandom_range(1, sw);
                th = ($urandom_range(0, 1)) ? sh : $urandom_range(1, 8191);
                n = $urandom_range(20, 40);
            end
            set_sizes(CFG_W'(sw), CFG_W'(sh), CFG_W'(tw), CFG_W'(th));
            if (!paused && pixels_taken > 200)
            begin
                // sender holds off mid-frame until the block has caught up
                queue_pixels(n / 2);
                drain();
                queue_pixels(n - n / 2);
                paused = 1;
            end
            else
                queue_pixels(n);
        end

        drain();
        repeat (SETTLE) @(posedge clk);
        $display("Covered %0d pixels over %0d size settings: %0d target pixels, %0d frames.",
                 pixels_taken, size_sets, pixels_out, frames_done);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin : watchdog
        #5000000;
        $display("Timed out with %0d results outstanding", expected_pixels.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule
